FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the serial programming master.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define HVSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the following cycle.
`define HVSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HVSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HVSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/hvsp_pkg.sv
// ----------------------------------------------------------------------------
// hvsp_pkg
// Types, codes and frame tables shared by the serial programming master.
// ----------------------------------------------------------------------------
`default_nettype none

package hvsp_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam logic [15:0] CFG_TIMEOUT_RESET = 16'd300;

    // Command codes.
    localparam logic [1:0] CMD_READ_SIG   = 2'd0;
    localparam logic [1:0] CMD_READ_FUSE  = 2'd1;
    localparam logic [1:0] CMD_WRITE_FUSE = 2'd2;
    localparam logic [1:0] CMD_RESERVED   = 2'd3;

    // Fuse select codes.
    localparam logic [1:0] FUSE_LOW      = 2'd0;
    localparam logic [1:0] FUSE_HIGH     = 2'd1;
    localparam logic [1:0] FUSE_EXT      = 2'd2;
    localparam logic [1:0] FUSE_RESERVED = 2'd3;

    // Input transaction after classification by the front end.
    typedef struct packed {
        logic       start_ok;
        logic [1:0] command;
        logic [1:0] fuse;
        logic [7:0] arg;
        logic       sdo;
    } item_t;

    // Status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Returns {data byte, instruction byte} of one frame.
    function automatic logic [15:0] frame_words(
        input logic [1:0] command,
        input logic [1:0] fuse,
        input logic [7:0] arg,
        input logic [1:0] idx
    );
        logic [1:0] f;
        logic [7:0] d;
        logic [7:0] ins;
        f   = (fuse == FUSE_RESERVED) ? FUSE_EXT : fuse;
        d   = 8'h00;
        ins = 8'h00;
        if (command == CMD_READ_SIG)
        begin
            case (idx)
                2'd0:    begin d = 8'h08; ins = 8'h4C; end
                2'd1:    begin d = arg;   ins = 8'h0C; end
                2'd2:    ins = 8'h68;
                default: ins = 8'h6C;
            endcase
        end
        else if (command == CMD_READ_FUSE)
        begin
            case (idx)
                2'd0:    begin d = 8'h04; ins = 8'h4C; end
                2'd1:    ins = (f == FUSE_LOW) ? 8'h68 : ((f == FUSE_HIGH) ? 8'h7A : 8'h6A);
                default: ins = (f == FUSE_LOW) ? 8'h6C : ((f == FUSE_HIGH) ? 8'h7E : 8'h6E);
            endcase
        end
        else
        begin
            case (idx)
                2'd0:    begin d = 8'h40; ins = 8'h4C; end
                2'd1:    begin d = arg;   ins = 8'h2C; end
                2'd2:    ins = (f == FUSE_LOW) ? 8'h64 : ((f == FUSE_HIGH) ? 8'h74 : 8'h66);
                default: ins = (f == FUSE_LOW) ? 8'h6C : ((f == FUSE_HIGH) ? 8'h7C : 8'h6E);
            endcase
        end
        return {d, ins};
    endfunction

endpackage

`default_nettype wire

FILE: design/hvsp_front.sv
// ----------------------------------------------------------------------------
// hvsp_front
// Accepts input transactions, unpacks them and marks legal start requests.
// ----------------------------------------------------------------------------
`default_nettype none

module hvsp_front
    import hvsp_pkg::*;
(
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire queue_stat_t q_stat,
    output logic             push,
    output item_t            push_item
);

    logic [1:0] command;
    logic [1:0] fuse;

    assign command = s_axis_tdata[1:0];
    assign fuse    = s_axis_tdata[3:2];

    // A start is legal for a known command, and for fuse commands only with
    // a known fuse. Whether the engine is busy is decided in the back end.
    always_comb
    begin
        push_item.start_ok = s_axis_tuser && (command != CMD_RESERVED)
                             && !((command != CMD_READ_SIG) && (fuse == FUSE_RESERVED));
        push_item.command  = command;
        push_item.fuse     = fuse;
        push_item.arg      = s_axis_tdata[11:4];
        push_item.sdo      = s_axis_tdata[12] | (|s_axis_tdata[15:13] & 1'b0);
    end

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full;

endmodule

`default_nettype wire

FILE: design/hvsp_queue.sv
// ----------------------------------------------------------------------------
// hvsp_queue
// Two-entry queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module hvsp_queue
    import hvsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head_item,
    output queue_stat_t q_stat
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head_item    = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

FILE: design/hvsp_engine.sv
// ----------------------------------------------------------------------------
// hvsp_engine
// Frame sequencer: ready waits, bit timing, capture and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hvsp_engine
    import hvsp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] timeout_ticks,
    input  wire item_t       head_item,
    input  wire queue_stat_t q_stat,
    output logic             pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;
    localparam logic [1:0] PH_HIGH = 2'd3;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    logic [1:0]            phase_reg,   phase_next;
    logic [1:0]            cmd_reg,     cmd_next;
    logic [1:0]            fuse_reg,    fuse_next;
    logic [7:0]            arg_reg,     arg_next;
    logic [1:0]            frame_reg,   frame_next;
    logic [3:0]            bit_reg,     bit_next;
    logic [10:0]           dshift_reg,  dshift_next;
    logic [10:0]           ishift_reg,  ishift_next;
    logic [10:0]           capture_reg, capture_next;
    logic [TIMER_BITS-1:0] wait_reg,    wait_next;
    logic                  tout_reg,    tout_next;

    logic                  out_valid_reg;
    logic [15:0]           out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;

    logic [15:0]           words;
    logic [TIMER_BITS-1:0] wait_inc;
    logic [CMP_W-1:0]      lim_raw;
    logic [CMP_W-1:0]      lim;
    logic [CMP_W-1:0]      cnt_ext;
    logic [1:0]            frame_inc;
    logic                  sdi, sii, sci, done;
    logic [7:0]            rdata;

    assign pop = !q_stat.empty && (!out_valid_reg || m_axis_tready);

    assign words     = frame_words(cmd_reg, fuse_reg, arg_reg, frame_reg);
    assign wait_inc  = (wait_reg == CNT_MAX) ? CNT_MAX : wait_reg + 1'b1;
    assign lim_raw   = (timeout_ticks == '0) ? CMP_W'(1) : CMP_W'(timeout_ticks);
    assign lim       = (lim_raw > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : lim_raw;
    assign cnt_ext   = CMP_W'(wait_inc);
    assign frame_inc = frame_reg + 1'b1;

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        fuse_next    = fuse_reg;
        arg_next     = arg_reg;
        frame_next   = frame_reg;
        bit_next     = bit_reg;
        dshift_next  = dshift_reg;
        ishift_next  = ishift_reg;
        capture_next = capture_reg;
        wait_next    = wait_reg;
        tout_next    = tout_reg;
        sdi          = 1'b0;
        sii          = 1'b0;
        sci          = 1'b0;
        done         = 1'b0;
        rdata        = 8'h00;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (head_item.start_ok)
                begin
                    cmd_next   = head_item.command;
                    fuse_next  = head_item.fuse;
                    arg_next   = head_item.arg;
                    frame_next = 2'd0;
                    wait_next  = '0;
                    tout_next  = 1'b0;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (head_item.sdo)
                begin
                    dshift_next  = {1'b0, words[15:8], 2'b00};
                    ishift_next  = {1'b0, words[7:0], 2'b00};
                    capture_next = '0;
                    bit_next     = 4'd10;
                    phase_next   = PH_LOW;
                end
                else
                begin
                    wait_next = wait_inc;
                    if (cnt_ext >= lim)
                    begin
                        tout_next    = 1'b1;
                        capture_next = '0;
                        done         = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            PH_LOW:
            begin
                sdi          = dshift_reg[bit_reg];
                sii          = ishift_reg[bit_reg];
                capture_next = {capture_reg[9:0], head_item.sdo};
                phase_next   = PH_HIGH;
            end
            PH_HIGH:
            begin
                sdi = dshift_reg[bit_reg];
                sii = ishift_reg[bit_reg];
                sci = 1'b1;
                if (bit_reg == 4'd0)
                begin
                    frame_next = frame_inc;
                    bit_next   = 4'd10;
                    // Read fuse uses three frames, the other commands four.
                    if ((frame_inc == 2'd0)
                        || ((cmd_reg == CMD_READ_FUSE) && (frame_inc == 2'd3)))
                    begin
                        done       = 1'b1;
                        rdata      = capture_reg[9:2];
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        wait_next  = '0;
                        phase_next = PH_WAIT;
                    end
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    phase_next = PH_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        out_data_next = {3'b000, tout_next, rdata, (phase_next != PH_IDLE), sci, sii, sdi};
        out_last_next = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= '0;
            fuse_reg      <= '0;
            arg_reg       <= '0;
            frame_reg     <= '0;
            bit_reg       <= 4'd10;
            dshift_reg    <= '0;
            ishift_reg    <= '0;
            capture_reg   <= '0;
            wait_reg      <= '0;
            tout_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg   <= phase_next;
                cmd_reg     <= cmd_next;
                fuse_reg    <= fuse_next;
                arg_reg     <= arg_next;
                frame_reg   <= frame_next;
                bit_reg     <= bit_next;
                dshift_reg  <= dshift_next;
                ishift_reg  <= ishift_next;
                capture_reg <= capture_next;
                wait_reg    <= wait_next;
                tout_reg    <= tout_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

FILE: design/hv_serial_programming_master_unit.sv
// A transaction accepted at the input is first written into the queue and then, when the
// engine pops it, into the result register, where its result can be taken.
// Throughput: one transaction per cycle while the queue is not full; the engine takes
// one queued tick per cycle whenever its output register is empty or being drained.
// Reset (rst_n, asynchronous, active low) empties the queue, puts the engine idle
// and loads the ready timeout register with 300 ticks.
// ----------------------------------------------------------------------------
// hv_serial_programming_master_unit
// High-voltage serial programming master: expands commands into target frames.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hv_serial_programming_master_unit
    import hvsp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Ready timeout register write port.
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,

    // Tick transactions in.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [1:0] command, [3:2] fuse_select, [11:4] arg_value, [12] sdo_level
    input  wire logic [15:0] s_axis_tdata,
    // [0] op
    input  wire logic        s_axis_tuser,

    // Result transactions out, one per tick.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] sdi_level, [1] sii_level, [2] sci_level, [3] busy_res,
    // [11:4] read_data, [12] timed_out
    output logic [15:0]      m_axis_tdata,
    // done_res: high on the transaction that completes a command.
    output logic             m_axis_tlast
);

    logic [15:0] timeout_reg;
    logic        push;
    item_t       push_item;
    item_t       head_item;
    queue_stat_t q_stat;
    logic        pop;

    // The timeout register must be written only while no transaction is in flight; the
    // block itself does not enforce this. The new value applies from the next queued tick on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= CFG_TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // The front end splits the transaction into fields and decides whether a
    // start request names a legal command; busy starts are dropped later.
    hvsp_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .push_item     (push_item)
    );

    // A short queue lets the input side keep flowing while the result
    // register waits on the consumer.
    hvsp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_stat    (q_stat)
    );

    // The engine steps the frame sequencer once per queued tick: ready wait
    // with timeout, then a low and a high clock phase for each of 11 bits.
    hvsp_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .head_item     (head_item),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A completed command always leaves the engine idle.
    `HVSP_ASSERT_IMP(a_done_not_busy, clk, rst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[3], "done with busy set")
    // Read data is only shown on the completing transaction.
    `HVSP_ASSERT_IMP(a_rdata_with_done, clk, rst_n, m_axis_tvalid && (m_axis_tdata[11:4] != 8'h00), m_axis_tlast, "read data without done")
    // The queue cannot be full and empty at once.
    `HVSP_ASSERT_IMP(a_queue_stat, clk, rst_n, q_stat.full, !q_stat.empty, "queue full and empty")
    // A popped tick always lands in the result register.
    `HVSP_ASSERT_NEXT(a_pop_result, clk, rst_n, pop, m_axis_tvalid, "popped tick without result")

endmodule

`default_nettype wire
